[design/bgh_pkg.sv]
// Package for the button gesture hotkey block: mode encoding, register
// indexes, configuration record and reset values. No dependencies.
`default_nettype none

package bgh_pkg;

   // Mode state, one-hot.
   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_PTT    = 3'b010,
      MODE_LOCKED = 3'b100
   } mode_type;

   // Mode codes as reported to the host side.
   localparam logic [1:0] MODE_CODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_CODE_PTT    = 2'd1;
   localparam logic [1:0] MODE_CODE_LOCKED = 2'd2;

   // Number of taps that, followed by a quiet window, lock recording.
   localparam logic [3:0] LOCK_TAPS = 4'd2;

   // Register file layout.
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0]  REG_HOLD_THRESHOLD = 3'd0;
   localparam logic [2:0]  REG_TAP_WINDOW     = 3'd1;
   localparam logic [2:0]  REG_RETURN_TAPS    = 3'd2;
   localparam logic [2:0]  REG_CONFIRM        = 3'd3;
   localparam logic [2:0]  REG_DIM_TIMEOUT    = 3'd4;

   localparam logic [15:0] HOLD_THRESHOLD_RESET = 16'd400;
   localparam logic [15:0] TAP_WINDOW_RESET     = 16'd350;
   localparam logic [3:0]  RETURN_TAPS_RESET    = 4'd3;
   localparam logic [15:0] CONFIRM_RESET        = 16'd800;
   localparam logic [19:0] DIM_TIMEOUT_RESET    = 20'd30000;

   typedef struct packed {
      logic [15:0] hold_threshold_ms;
      logic [15:0] tap_window_ms;
      logic [3:0]  return_tap_count;
      logic [15:0] confirm_ms;
      logic [19:0] dim_timeout_ms;
   } cfg_type;

   function automatic logic [1:0] mode_code(input mode_type m);
      logic [1:0] code;
      case (m)
         MODE_PTT:    code = MODE_CODE_PTT;
         MODE_LOCKED: code = MODE_CODE_LOCKED;
         default:     code = MODE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[design/bgh_if.sv]
// Handshake interfaces for the tick channel and the result channel of the
// button gesture hotkey block. No dependencies.
`default_nettype none

interface bgh_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic        link_up;
   logic        button_down;
   logic        press_edge;
   logic        release_edge;
   logic        update_busy;

   modport source (output valid, now_ms, link_up, button_down, press_edge,
                   release_edge, update_busy, input ready);
   modport sink   (input valid, now_ms, link_up, button_down, press_edge,
                   release_edge, update_busy, output ready);
endinterface

interface bgh_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic        combo_held;
   logic        return_key;
   logic        confirming;
   logic        display_dim;
   logic        clip_done;
   logic [31:0] clip_length_ms;

   modport source (output valid, mode, combo_held, return_key, confirming,
                   display_dim, clip_done, clip_length_ms, input ready);
   modport sink   (input valid, mode, combo_held, return_key, confirming,
                   display_dim, clip_done, clip_length_ms, output ready);
endinterface

`default_nettype wire

[design/bgh_csr.sv]
// APB-style configuration registers of the button gesture hotkey block.
// Depends on bgh_pkg for the register layout and the configuration record.
`default_nettype none

module bgh_csr
   import bgh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   logic [2:0] reg_index;
   logic       write_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_threshold_ms <= HOLD_THRESHOLD_RESET;
         cfg_ff.tap_window_ms     <= TAP_WINDOW_RESET;
         cfg_ff.return_tap_count  <= RETURN_TAPS_RESET;
         cfg_ff.confirm_ms        <= CONFIRM_RESET;
         cfg_ff.dim_timeout_ms    <= DIM_TIMEOUT_RESET;
      end else if (write_en) begin
         case (reg_index)
            REG_HOLD_THRESHOLD: cfg_ff.hold_threshold_ms <= csr_pwdata[15:0];
            REG_TAP_WINDOW:     cfg_ff.tap_window_ms     <= csr_pwdata[15:0];
            REG_RETURN_TAPS:    cfg_ff.return_tap_count  <= csr_pwdata[3:0];
            REG_CONFIRM:        cfg_ff.confirm_ms        <= csr_pwdata[15:0];
            REG_DIM_TIMEOUT:    cfg_ff.dim_timeout_ms    <= csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_HOLD_THRESHOLD: csr_prdata = {16'd0, cfg_ff.hold_threshold_ms};
         REG_TAP_WINDOW:     csr_prdata = {16'd0, cfg_ff.tap_window_ms};
         REG_RETURN_TAPS:    csr_prdata = {28'd0, cfg_ff.return_tap_count};
         REG_CONFIRM:        csr_prdata = {16'd0, cfg_ff.confirm_ms};
         REG_DIM_TIMEOUT:    csr_prdata = {12'd0, cfg_ff.dim_timeout_ms};
         default:            csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

[design/button_gesture_hotkey_fsm.sv]
// Top level of the button gesture hotkey block: tick processing and result register.
// Depends on bgh_pkg, the interfaces in bgh_if and the register file bgh_csr.
//
//   channel  direction  handshake                 content
//   req_if   in         valid/ready               one tick: time, link, button, busy
//   rsp_if   out        valid/ready               one result per tick
//   csr_*    in/out     APB-style, pready high    five configuration registers
//
// Each accepted tick is processed at once: the state update and the result are
// computed combinationally from the stored state and registered at the accepting
// edge, so the result shows in the next cycle, and one tick can be accepted in every
// cycle while each result is taken. The result register is the only buffer; a tick
// is taken whenever it is empty or is being drained in the same cycle. Reset is
// synchronous and restores the power-on state and register values.
`default_nettype none

module button_gesture_hotkey_fsm
   import bgh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   bgh_req_if.sink                    req_if,
   bgh_rsp_if.source                  rsp_if,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   cfg_type cfg;

   bgh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Gesture state.
   mode_type    mode_ff, mode_in;
   logic        was_linked_ff, was_linked_in;
   logic        tap_pending_ff, tap_pending_in;
   logic [3:0]  tap_count_ff, tap_count_in;
   logic [31:0] last_tap_ff, last_tap_in;
   logic [31:0] press_start_ff, press_start_in;
   logic        confirm_ff, confirm_in;
   logic [31:0] return_time_ff, return_time_in;
   logic [31:0] record_start_ff, record_start_in;
   logic [31:0] last_clip_ff, last_clip_in;
   logic [31:0] last_activity_ff, last_activity_in;
   logic        dimmed_ff, dimmed_in;
   logic        return_pulse;
   logic        clip_pulse;
   logic [3:0]  tap_done;

   // Result register.
   logic        rsp_valid_ff;
   logic [1:0]  rsp_mode_ff;
   logic        rsp_return_ff;
   logic        rsp_confirm_ff;
   logic        rsp_dim_ff;
   logic        rsp_clip_done_ff;
   logic [31:0] rsp_clip_len_ff;

   logic        req_accept;
   logic [31:0] now;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;
   assign now          = req_if.now_ms;

   // Tick processing. The steps follow the order link, button press, hold,
   // release, tap sequence end, confirmation end and dimming; later steps see
   // the values that earlier steps have just produced.
   always_comb begin
      mode_in          = mode_ff;
      was_linked_in    = was_linked_ff;
      tap_pending_in   = tap_pending_ff;
      tap_count_in     = tap_count_ff;
      last_tap_in      = last_tap_ff;
      press_start_in   = press_start_ff;
      confirm_in       = confirm_ff;
      return_time_in   = return_time_ff;
      record_start_in  = record_start_ff;
      last_clip_in     = last_clip_ff;
      last_activity_in = last_activity_ff;
      dimmed_in        = dimmed_ff;
      return_pulse     = 1'b0;
      clip_pulse       = 1'b0;
      tap_done         = 4'd0;

      // Link transitions. A link that comes up ends any recording with a
      // clip report; a link that drops abandons it silently.
      if (req_if.link_up && !was_linked_ff) begin
         if (mode_in != MODE_IDLE) begin
            last_clip_in = now - record_start_in;
            clip_pulse   = 1'b1;
         end
         mode_in          = MODE_IDLE;
         tap_pending_in   = 1'b0;
         tap_count_in     = 4'd0;
         confirm_in       = 1'b0;
         last_activity_in = now;
         dimmed_in        = 1'b0;
      end else if (!req_if.link_up && was_linked_ff) begin
         mode_in          = MODE_IDLE;
         tap_pending_in   = 1'b0;
         tap_count_in     = 4'd0;
         confirm_in       = 1'b0;
         last_activity_in = now;
         dimmed_in        = 1'b0;
      end
      was_linked_in = req_if.link_up;

      if (req_if.link_up) begin
         // Press: a stale tap sequence is dropped and the press start noted.
         if (req_if.press_edge) begin
            last_activity_in = now;
            dimmed_in        = 1'b0;
            if (tap_pending_in && ((now - last_tap_in) > {16'd0, cfg.tap_window_ms})) begin
               tap_pending_in = 1'b0;
               tap_count_in   = 4'd0;
            end
            press_start_in = now;
         end

         // Long hold from idle starts push-to-talk.
         if ((mode_in == MODE_IDLE) && req_if.button_down &&
             ((now - press_start_in) >= {16'd0, cfg.hold_threshold_ms})) begin
            record_start_in  = now;
            tap_pending_in   = 1'b0;
            tap_count_in     = 4'd0;
            confirm_in       = 1'b0;
            mode_in          = MODE_PTT;
            last_activity_in = now;
            dimmed_in        = 1'b0;
         end

         // Release: ends a recording, or counts as a short tap when idle.
         if (req_if.release_edge) begin
            last_activity_in = now;
            dimmed_in        = 1'b0;
            if (mode_in != MODE_IDLE) begin
               last_clip_in     = now - record_start_in;
               clip_pulse       = 1'b1;
               mode_in          = MODE_IDLE;
               tap_pending_in   = 1'b0;
               tap_count_in     = 4'd0;
               confirm_in       = 1'b0;
            end else if ((now - press_start_in) < {16'd0, cfg.hold_threshold_ms}) begin
               if (!tap_pending_in ||
                   ((now - last_tap_in) > {16'd0, cfg.tap_window_ms})) begin
                  tap_count_in = 4'd0;
               end
               tap_pending_in = 1'b1;
               last_tap_in    = now;
               tap_count_in   = tap_count_in + 4'd1;
               // Enough taps in a row send one return keystroke.
               if (tap_count_in >= cfg.return_tap_count) begin
                  tap_pending_in   = 1'b0;
                  tap_count_in     = 4'd0;
                  return_pulse     = 1'b1;
                  return_time_in   = now;
                  confirm_in       = 1'b1;
                  last_activity_in = now;
                  dimmed_in        = 1'b0;
               end
            end
         end

         // A tap sequence closes once the window passes with the button up;
         // exactly the lock count of taps enters locked recording.
         if (tap_pending_in && !req_if.button_down &&
             ((now - last_tap_in) > {16'd0, cfg.tap_window_ms})) begin
            tap_done       = tap_count_in;
            tap_pending_in = 1'b0;
            tap_count_in   = 4'd0;
            if (tap_done == LOCK_TAPS) begin
               record_start_in  = now;
               confirm_in       = 1'b0;
               mode_in          = MODE_LOCKED;
               last_activity_in = now;
               dimmed_in        = 1'b0;
            end
         end

         // Confirmation period end.
         if (confirm_in && ((now - return_time_in) >= {16'd0, cfg.confirm_ms})) begin
            confirm_in = 1'b0;
            if ((mode_in == MODE_IDLE) && !req_if.update_busy) begin
               last_activity_in = now;
               dimmed_in        = 1'b0;
            end
         end
      end

      // Dimming: never while recording, held off while an update runs.
      if (mode_in != MODE_IDLE) begin
         dimmed_in = 1'b0;
      end else if (req_if.update_busy) begin
         last_activity_in = now;
         dimmed_in        = 1'b0;
      end else if (!dimmed_in &&
                   ((now - last_activity_in) >= {12'd0, cfg.dim_timeout_ms})) begin
         dimmed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_IDLE;
         was_linked_ff    <= 1'b0;
         tap_pending_ff   <= 1'b0;
         tap_count_ff     <= 4'd0;
         last_tap_ff      <= 32'd0;
         press_start_ff   <= 32'd0;
         confirm_ff       <= 1'b0;
         return_time_ff   <= 32'd0;
         record_start_ff  <= 32'd0;
         last_clip_ff     <= 32'd0;
         last_activity_ff <= 32'd0;
         dimmed_ff        <= 1'b0;
      end else if (req_accept) begin
         mode_ff          <= mode_in;
         was_linked_ff    <= was_linked_in;
         tap_pending_ff   <= tap_pending_in;
         tap_count_ff     <= tap_count_in;
         last_tap_ff      <= last_tap_in;
         press_start_ff   <= press_start_in;
         confirm_ff       <= confirm_in;
         return_time_ff   <= return_time_in;
         record_start_ff  <= record_start_in;
         last_clip_ff     <= last_clip_in;
         last_activity_ff <= last_activity_in;
         dimmed_ff        <= dimmed_in;
      end
   end

   // Result register: filled on every accepted transaction, emptied when the
   // downstream side takes it without a new tick arriving.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_mode_ff      <= mode_code(mode_in);
         rsp_return_ff    <= return_pulse;
         rsp_confirm_ff   <= confirm_in;
         rsp_dim_ff       <= dimmed_in;
         rsp_clip_done_ff <= clip_pulse;
         rsp_clip_len_ff  <= last_clip_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.mode           = rsp_mode_ff;
   assign rsp_if.combo_held     = (rsp_mode_ff != MODE_CODE_IDLE);
   assign rsp_if.return_key     = rsp_return_ff;
   assign rsp_if.confirming     = rsp_confirm_ff;
   assign rsp_if.display_dim    = rsp_dim_ff;
   assign rsp_if.clip_done      = rsp_clip_done_ff;
   assign rsp_if.clip_length_ms = rsp_clip_len_ff;

   // Every accepted tick leaves a result waiting in the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted tick left no result");

   // A return keystroke only comes from a tap while idle.
   a_return_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_return_ff) |-> (rsp_mode_ff == MODE_CODE_IDLE))
      else $error("return key sent outside idle");

   // The display is never dimmed while a recording runs.
   a_dim_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dim_ff) |-> (rsp_mode_ff == MODE_CODE_IDLE))
      else $error("display dimmed while recording");

   // The stored mode and the reported mode agree once a result is shown.
   a_mode_match: assert property (@(posedge clock) disable iff (reset)
      ($past(req_accept) && rsp_valid_ff) |-> (rsp_mode_ff == mode_code(mode_ff)))
      else $error("reported mode differs from stored mode");

endmodule

`default_nettype wire
